[hdl/limit_order_matcher_macros.svh]
// Assertion macros for the limit order matcher.
// Used by the modules that carry concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef LIMIT_ORDER_MATCHER_MACROS_SVH
`define LIMIT_ORDER_MATCHER_MACROS_SVH
`ifndef ASSERT_OFF
`define LOM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LOM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LOM_ASSERT_IMP(lbl, ante, cons)
`define LOM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[hdl/lom_pkg.sv]
// Shared types for the limit order matcher.
// Command and status groups between controller and datapath; no dependencies.
package lom_pkg;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic rd_sum;
        logic scan_clr;
        logic fill;
        logic rest;
        logic out_load;
        logic out_final;
    } t_cmd;

    typedef struct packed {
        logic qty_zero;
        logic found;
        logic have_pend;
        logic out_free;
        logic fill_ends;
    } t_status;

endpackage

[hdl/lom_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/lom_ctrl.sv]
// Controller for the limit order matcher: sequences match scans, fills,
// resting and the book summary scan. Uses lom_pkg and the assertion macros.
`include "limit_order_matcher_macros.svh"
module lom_ctrl #(
    parameter int BOOK_CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  lom_pkg::t_status                 i_status,
    output lom_pkg::t_cmd                    o_cmd,
    output logic [$clog2(BOOK_CAPACITY)-1:0] o_rd_addr
);

    localparam int AW = $clog2(BOOK_CAPACITY);
    localparam int NW = $clog2(BOOK_CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_MSCAN = 4'd2;
    localparam logic [3:0] S_MDEC  = 4'd3;
    localparam logic [3:0] S_EMIT  = 4'd4;
    localparam logic [3:0] S_FILL  = 4'd5;
    localparam logic [3:0] S_REST  = 4'd6;
    localparam logic [3:0] S_SSCAN = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;

    logic [3:0]    r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          w_scan, w_scan_end;

    assign w_scan     = (r_state == S_MSCAN) || (r_state == S_SSCAN);
    assign w_scan_end = (r_cnt == NW'(BOOK_CAPACITY));
    assign o_s_tready = (r_state == S_IDLE);
    assign o_rd_addr  = r_cnt[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.rd_en    = w_scan && !w_scan_end;
        o_cmd.rd_sum   = (r_state == S_SSCAN);
        o_cmd.scan_clr = w_scan && (r_cnt == '0);
        if (w_scan) begin
            n_cnt = r_cnt + NW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_cnt   = '0;
                n_state = i_status.qty_zero ? S_REST : S_MSCAN;
            end
            S_MSCAN: begin
                if (w_scan_end) begin
                    n_state = S_MDEC;
                end
            end
            S_MDEC: begin
                if (!i_status.found) begin
                    n_state = S_REST;
                end else if (i_status.have_pend) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_cnt   = '0;
                n_state = i_status.fill_ends ? S_REST : S_MSCAN;
            end
            S_REST: begin
                o_cmd.rest = 1'b1;
                n_cnt   = '0;
                n_state = S_SSCAN;
            end
            S_SSCAN: begin
                if (w_scan_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_final = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `LOM_ASSERT_IMP(a_load_free, o_cmd.out_load, i_status.out_free)
    `LOM_ASSERT_NXT(a_accept_start, i_s_tvalid && o_s_tready, r_state == S_START)
    `LOM_ASSERT_NXT(a_mscan_dec, (r_state == S_MSCAN) && w_scan_end, r_state == S_MDEC)
    `LOM_ASSERT_IMP(a_fill_found, o_cmd.fill, !i_status.qty_zero)

endmodule

[hdl/lom_dp.sv]
// Datapath for the limit order matcher: entry RAM, valid bits, scan
// accumulators, fill arithmetic and the output register. Uses lom_pkg, lom_ram.
module lom_dp #(
    parameter int BOOK_CAPACITY = 64,
    parameter int PRICE_BITS    = 16,
    parameter int QTY_BITS      = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  lom_pkg::t_cmd                    i_cmd,
    input  logic [$clog2(BOOK_CAPACITY)-1:0] i_rd_addr,
    output lom_pkg::t_status                 o_status,
    input  logic                             i_side,
    input  logic [PRICE_BITS-1:0]            i_price,
    input  logic [QTY_BITS-1:0]              i_qty,
    input  logic                             i_m_tready,
    output logic                             o_m_tvalid,
    output logic                             o_trade_valid,
    output logic                             o_last,
    output logic [5*PRICE_BITS+QTY_BITS+35:0] o_fields
);

    localparam int P  = PRICE_BITS;
    localparam int Q  = QTY_BITS;
    localparam int AW = $clog2(BOOK_CAPACITY);
    localparam int NW = $clog2(BOOK_CAPACITY + 1);
    localparam int EW = 33 + P + Q;
    localparam int OW = 5 * P + Q + 36;

    logic [BOOK_CAPACITY-1:0] r_used;
    logic [31:0]   r_next_seq, r_id;
    logic          r_side;
    logic [P-1:0]  r_price;
    logic [Q-1:0]  r_qty;
    logic          r_acc_vld, r_acc_sum;
    logic [AW-1:0] r_acc_idx;
    logic          r_found;
    logic [AW-1:0] r_bidx;
    logic [EW-1:0] r_bent;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;
    logic [NW-1:0] r_nfill;
    logic          r_pend;
    logic [P-1:0]  r_pprice;
    logic [Q-1:0]  r_pqty;
    logic          r_dropped;
    logic          r_hb, r_ha;
    logic [P-1:0]  r_maxb, r_minb, r_maxa, r_mina;
    logic          r_ovld, r_otv, r_olast;
    logic [OW-1:0] r_odata;

    logic [EW-1:0] w_rdata, w_wdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_d_sell, w_b_sell, w_d_used;
    logic [P-1:0]  w_d_price, w_b_price;
    logic [Q-1:0]  w_b_rem, w_fill;
    logic [31:0]   w_d_seq, w_b_seq;
    logic          w_cand, w_better, w_do_rest;
    logic [P:0]    w_mid_sum, w_depth;
    logic [OW-1:0] w_odata;

    assign w_d_sell  = w_rdata[0];
    assign w_d_price = w_rdata[P:1];
    assign w_d_seq   = w_rdata[EW-1:P+Q+1];
    assign w_b_sell  = r_bent[0];
    assign w_b_price = r_bent[P:1];
    assign w_b_rem   = r_bent[P+Q:P+1];
    assign w_b_seq   = r_bent[EW-1:P+Q+1];
    assign w_d_used  = r_used[r_acc_idx];

    assign w_fill    = (r_qty < w_b_rem) ? r_qty : w_b_rem;
    assign w_do_rest = i_cmd.rest && (r_qty != '0) && r_free_found;
    assign w_we      = i_cmd.fill || w_do_rest;
    assign w_waddr   = i_cmd.fill ? r_bidx : r_free_idx;
    assign w_wdata   = i_cmd.fill ? {w_b_seq, w_b_rem - w_fill, w_b_price, w_b_sell}
                                  : {r_id, r_qty, r_price, r_side};

    lom_ram #(
        .WIDTH(EW),
        .DEPTH(BOOK_CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(i_rd_addr),
        .o_rdata(w_rdata)
    );

    assign w_cand = w_d_used && (w_d_sell != r_side) &&
                    (r_side ? (w_d_price >= r_price) : (w_d_price <= r_price));
    always_comb begin
        if (!r_found) begin
            w_better = 1'b1;
        end else if (w_d_price == w_b_price) begin
            w_better = w_d_seq < w_b_seq;
        end else begin
            w_better = r_side ? (w_d_price > w_b_price) : (w_d_price < w_b_price);
        end
    end

    assign w_mid_sum = {1'b0, r_mina} + {1'b0, r_maxb};
    assign w_depth   = {1'b0, r_maxa} - {1'b0, r_minb};

    always_comb begin
        w_odata = '0;
        if (!i_cmd.out_final || r_pend) begin
            w_odata[P-1:0]        = r_pprice;
            w_odata[P+Q-1:P]      = r_pqty;
        end
        w_odata[P+Q+31:P+Q] = r_id;
        if (i_cmd.out_final) begin
            w_odata[2*P+Q+31:P+Q+32]   = r_hb ? r_maxb : '0;
            w_odata[3*P+Q+31:2*P+Q+32] = r_ha ? r_mina : '0;
            w_odata[3*P+Q+32]          = r_hb;
            w_odata[3*P+Q+33]          = r_ha;
            if (r_hb && r_ha) begin
                w_odata[4*P+Q+33:3*P+Q+34] = w_mid_sum[P:1];
                w_odata[5*P+Q+34:4*P+Q+34] = w_depth;
            end
            w_odata[5*P+Q+35] = r_dropped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_next_seq <= '0;
            r_acc_vld  <= 1'b0;
            r_ovld     <= 1'b0;
            r_pend     <= 1'b0;
        end else begin
            r_acc_vld <= i_cmd.rd_en;
            if (i_cmd.load) begin
                r_next_seq <= r_next_seq + 32'd1;
                r_pend     <= 1'b0;
            end
            if (i_cmd.fill) begin
                r_pend <= 1'b1;
                if (w_fill == w_b_rem) begin
                    r_used[r_bidx] <= 1'b0;
                end
            end
            if (w_do_rest) begin
                r_used[r_free_idx] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_sum <= i_cmd.rd_sum;
        r_acc_idx <= i_rd_addr;
        if (i_cmd.load) begin
            r_id      <= r_next_seq;
            r_side    <= i_side;
            r_price   <= i_price;
            r_qty     <= i_qty;
            r_nfill   <= '0;
            r_dropped <= 1'b0;
        end
        if (i_cmd.scan_clr && !i_cmd.rd_sum) begin
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
        end else if (r_acc_vld && !r_acc_sum) begin
            if (w_cand && w_better) begin
                r_found <= 1'b1;
                r_bidx  <= r_acc_idx;
                r_bent  <= w_rdata;
            end
            if (!w_d_used && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_acc_idx;
            end
        end
        if (i_cmd.fill) begin
            r_pprice <= w_b_price;
            r_pqty   <= w_fill;
            r_qty    <= r_qty - w_fill;
            r_nfill  <= r_nfill + NW'(1);
            if ((w_fill == w_b_rem) && (!r_free_found || (r_bidx < r_free_idx))) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_bidx;
            end
        end
        if (i_cmd.rest && (r_qty != '0) && !r_free_found) begin
            r_dropped <= 1'b1;
        end
        if (i_cmd.scan_clr && i_cmd.rd_sum) begin
            r_hb <= 1'b0;
            r_ha <= 1'b0;
        end else if (r_acc_vld && r_acc_sum && w_d_used) begin
            if (w_d_sell) begin
                r_ha <= 1'b1;
                if (!r_ha || (w_d_price < r_mina)) r_mina <= w_d_price;
                if (!r_ha || (w_d_price > r_maxa)) r_maxa <= w_d_price;
            end else begin
                r_hb <= 1'b1;
                if (!r_hb || (w_d_price < r_minb)) r_minb <= w_d_price;
                if (!r_hb || (w_d_price > r_maxb)) r_maxb <= w_d_price;
            end
        end
        if (i_cmd.out_load) begin
            r_odata <= w_odata;
            r_otv   <= !i_cmd.out_final || r_pend;
            r_olast <= i_cmd.out_final;
        end
    end

    assign o_status.qty_zero  = (r_qty == '0);
    assign o_status.found     = r_found;
    assign o_status.have_pend = r_pend;
    assign o_status.out_free  = !r_ovld || i_m_tready;
    assign o_status.fill_ends = (r_qty <= w_b_rem) || (r_nfill == NW'(BOOK_CAPACITY - 1));

    assign o_m_tvalid    = r_ovld;
    assign o_trade_valid = r_otv;
    assign o_last        = r_olast;
    assign o_fields      = r_odata;

endmodule

[hdl/limit_order_matcher.sv]
// Limit order matcher with price-time priority over a table of resting orders.
// Every scan walks the entry RAM one entry per cycle through its single read port.
// An order with no fill goes through accept, start, match scan, decision, rest,
// summary scan and final item; a zero quantity order skips the match scan and the
// decision. Each fill adds another match scan, decision, fill and emit of the
// previous fill, and the emit and the final item wait while the output side stalls.
// The input is ready only while idle. Each fill gives one item; the last item of
// an order carries tlast and the book summary. Uses lom_pkg, lom_ctrl, lom_dp.
module limit_order_matcher #(
    parameter int BOOK_CAPACITY = 64,
    parameter int PRICE_BITS    = 16,
    parameter int QTY_BITS      = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // limit_price, order_qty
    input  logic [((PRICE_BITS+QTY_BITS+7)/8)*8-1:0] i_s_tdata,
    // side
    input  logic i_s_tuser,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // trade_price, trade_qty, new_order_id, best_bid, best_ask, bid_present,
    // ask_present, mid_price, book_depth, dropped
    output logic [((5*PRICE_BITS+QTY_BITS+36+7)/8)*8-1:0] o_m_tdata,
    // trade_valid
    output logic o_m_tuser,
    output logic o_m_tlast
);

    localparam int OW  = 5 * PRICE_BITS + QTY_BITS + 36;
    localparam int OTW = ((OW + 7) / 8) * 8;

    lom_pkg::t_cmd                    w_cmd;
    lom_pkg::t_status                 w_status;
    logic [$clog2(BOOK_CAPACITY)-1:0] w_rd_addr;
    logic [OW-1:0]                    w_fields;

    lom_ctrl #(
        .BOOK_CAPACITY(BOOK_CAPACITY)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd),
        .o_rd_addr (w_rd_addr)
    );

    lom_dp #(
        .BOOK_CAPACITY(BOOK_CAPACITY),
        .PRICE_BITS   (PRICE_BITS),
        .QTY_BITS     (QTY_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_rd_addr    (w_rd_addr),
        .o_status     (w_status),
        .i_side       (i_s_tuser),
        .i_price      (i_s_tdata[PRICE_BITS-1:0]),
        .i_qty        (i_s_tdata[PRICE_BITS+QTY_BITS-1:PRICE_BITS]),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_trade_valid(o_m_tuser),
        .o_last       (o_m_tlast),
        .o_fields     (w_fields)
    );

    assign o_m_tdata = OTW'(w_fields);

endmodule

[tb/tb.sv]
// Testbench for limit_order_matcher: drives limit orders, predicts the fills and
// the book summary with its own book copy, and checks every output item in order.
// Depends on the limit_order_matcher RTL only.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH_N   = 64;
    localparam int LIMIT_CYC = 10000000;

    typedef struct packed {
        logic        trade_valid;
        logic [15:0] trade_price;
        logic [15:0] trade_qty;
        logic [31:0] order_id;
        logic [15:0] best_bid;
        logic [15:0] best_ask;
        logic        bid_present;
        logic        ask_present;
        logic [15:0] mid_price;
        logic [16:0] book_depth;
        logic        dropped;
        logic        last;
    } t_report;

    typedef struct {
        bit        sell;
        bit [15:0] price;
        bit [15:0] qty;
        bit        typed;
        t_report   want;
    } t_order_row;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_s_tvalid = 0;
    logic         o_s_tready;
    logic [31:0]  i_s_tdata = '0;   // limit_price, order_qty
    logic         i_s_tuser = 0;    // side
    logic         o_m_tvalid;
    logic         i_m_tready = 0;
    logic [135:0] o_m_tdata;        // trade_price .. dropped
    logic         o_m_tuser;        // trade_valid
    logic         o_m_tlast;

    limit_order_matcher u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    // predictor book
    bit        bk_used[DEPTH_N];
    bit        bk_sell[DEPTH_N];
    bit [15:0] bk_price[DEPTH_N];
    bit [15:0] bk_rem[DEPTH_N];
    bit [31:0] bk_seq[DEPTH_N];
    bit [31:0] seq_next;

    t_report fills_due[$];
    int      errors = 0;
    int      cycles = 0;
    bit      gaps_on = 1;
    bit      hold_rx = 0;

    function automatic int best_resting(bit sell, bit [15:0] px);
        int b;
        bit better;
        b = -1;
        for (int i = 0; i < DEPTH_N; i++) begin
            if (!bk_used[i] || bk_sell[i] == sell) continue;
            if (sell ? (bk_price[i] < px) : (bk_price[i] > px)) continue;
            if (b < 0) better = 1;
            else if (bk_price[i] == bk_price[b]) better = bk_seq[i] < bk_seq[b];
            else better = sell ? (bk_price[i] > bk_price[b]) : (bk_price[i] < bk_price[b]);
            if (better) b = i;
        end
        return b;
    endfunction

    function automatic int book_count();
        int c;
        c = 0;
        foreach (bk_used[i]) c += bk_used[i];
        return c;
    endfunction

    function automatic void match_order(bit sell, bit [15:0] px, bit [15:0] q);
        t_report   r;
        int        n, b, slot;
        bit [15:0] f, maxb, minb, mina, maxa;
        bit        hb, ha;
        bit [31:0] id;
        n = 0; hb = 0; ha = 0;
        maxb = 0; minb = 0; mina = 0; maxa = 0;
        id = seq_next;
        seq_next++;
        while (q > 0 && n < DEPTH_N) begin
            b = best_resting(sell, px);
            if (b < 0) break;
            f = (q < bk_rem[b]) ? q : bk_rem[b];
            r = '0;
            r.trade_valid = 1;
            r.trade_price = bk_price[b];
            r.trade_qty = f;
            r.order_id = id;
            fills_due.insert(fills_due.size(), r);
            n++;
            q -= f;
            bk_rem[b] -= f;
            if (bk_rem[b] == 0) bk_used[b] = 0;
        end
        r = '0;
        if (q > 0) begin
            slot = -1;
            for (int i = 0; i < DEPTH_N; i++)
                if (!bk_used[i] && slot < 0) slot = i;
            if (slot < 0) r.dropped = 1;
            else begin
                bk_used[slot] = 1;
                bk_sell[slot] = sell;
                bk_price[slot] = px;
                bk_rem[slot] = q;
                bk_seq[slot] = id;
            end
        end
        for (int i = 0; i < DEPTH_N; i++) begin
            if (!bk_used[i]) continue;
            if (bk_sell[i]) begin
                if (!ha || bk_price[i] < mina) mina = bk_price[i];
                if (!ha || bk_price[i] > maxa) maxa = bk_price[i];
                ha = 1;
            end else begin
                if (!hb || bk_price[i] < minb) minb = bk_price[i];
                if (!hb || bk_price[i] > maxb) maxb = bk_price[i];
                hb = 1;
            end
        end
        if (n > 0) r = {fills_due.pop_back()} | r;
        else r.order_id = id;
        r.best_bid = hb ? maxb : 16'd0;
        r.best_ask = ha ? mina : 16'd0;
        r.bid_present = hb;
        r.ask_present = ha;
        if (hb && ha) begin
            r.mid_price = 16'(({1'b0, mina} + {1'b0, maxb}) >> 1);
            r.book_depth = {1'b0, maxa} - {1'b0, minb};
        end
        r.last = 1;
        fills_due.insert(fills_due.size(), r);
    endfunction

    task automatic send_order(bit sell, bit [15:0] px, bit [15:0] q,
                              bit typed = 0, t_report want = '0);
        int g;
        i_s_tvalid <= 1;
        i_s_tuser <= sell;
        i_s_tdata <= {q, px};
        do @(posedge i_clk); while (!o_s_tready);
        match_order(sell, px, q);
        if (typed) begin
            void'(fills_due.pop_back());
            fills_due.insert(fills_due.size(), want);
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 0;
            i_s_tdata <= $urandom;
            g = $urandom_range(1, 4);
            repeat (g) @(posedge i_clk);
        end
    endtask

    // receiver with random stall bursts and one long hold-off per request
    int stall_left = 0;
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (hold_rx && hold_left == 0) begin
            hold_left = 400;
            hold_rx = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            i_m_tready <= 0;
        end else begin
            i_m_tready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        t_report got, exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[63:32],
                   o_m_tdata[79:64], o_m_tdata[95:80], o_m_tdata[96], o_m_tdata[97],
                   o_m_tdata[113:98], o_m_tdata[130:114], o_m_tdata[131], o_m_tlast};
            if (fills_due.size() == 0) begin
                errors++;
                $display("%0t unexpected item %p", $time, got);
            end else begin
                exp_r = fills_due.pop_front();
                if (got !== exp_r) begin
                    errors++;
                    $display("%0t mismatch expected %p actual %p", $time, exp_r, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_report summary(bit [31:0] id, bit [15:0] bb, bit [15:0] ba,
                                        bit bp, bit ap, bit [15:0] mid, bit [16:0] dep);
        t_report r;
        r = '0;
        r.order_id = id;
        r.best_bid = bb;
        r.best_ask = ba;
        r.bid_present = bp;
        r.ask_present = ap;
        r.mid_price = mid;
        r.book_depth = dep;
        r.last = 1;
        return r;
    endfunction

    t_order_row plan[$];

    initial begin
        int n_rand;
        int pick;
        bit        s;
        bit [15:0] p, q;
        plan.insert(plan.size(), '{1'b0, 16'd100, 16'd10, 1'b1,
            summary(32'd0, 16'd100, 16'd0, 1'b1, 1'b0, 16'd0, 17'd0)});
        plan.insert(plan.size(), '{1'b1, 16'd0, 16'd0, 1'b1,
            summary(32'd1, 16'd100, 16'd0, 1'b1, 1'b0, 16'd0, 17'd0)});
        plan.insert(plan.size(), '{1'b1, 16'hFFFF, 16'hFFFF, 1'b1,
            summary(32'd2, 16'd100, 16'hFFFF, 1'b1, 1'b1, 16'd32817, 17'd65435)});
        plan.insert(plan.size(), '{1'b0, 16'd0, 16'd1, 1'b1,
            summary(32'd3, 16'd100, 16'hFFFF, 1'b1, 1'b1, 16'd32817, 17'd65535)});
        plan.insert(plan.size(), '{1'b1, 16'd100, 16'd5, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'd0, 16'hFFFF, 1'b0, '0});
        plan.insert(plan.size(), '{1'b0, 16'hFFFF, 16'hFFFF, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'hFFFF, 16'hFFFF, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'd600, 16'd3, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'd600, 16'd4, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'd599, 16'd2, 1'b0, '0});
        plan.insert(plan.size(), '{1'b0, 16'd650, 16'd8, 1'b0, '0});
        plan.insert(plan.size(), '{1'b0, 16'd0, 16'd0, 1'b0, '0});
        plan.insert(plan.size(), '{1'b0, 16'h5555, 16'hAAAA, 1'b0, '0});
        plan.insert(plan.size(), '{1'b1, 16'hAAAA, 16'h5555, 1'b0, '0});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        foreach (plan[i])
            send_order(plan[i].sell, plan[i].price, plan[i].qty,
                       plan[i].typed, plan[i].want);
        i_s_tvalid <= 0;
        wait (fills_due.size() == 0);
        @(posedge i_clk);

        // fill the book with resting bids, spill some, then sweep them all
        while (book_count() < DEPTH_N)
            send_order(1'b0, 16'($urandom_range(500, 599)), 16'($urandom_range(1, 900)));
        hold_rx = 1;
        repeat (4) send_order(1'b0, 16'($urandom_range(0, 499)), 16'($urandom_range(1, 900)));
        hold_rx = 0;
        send_order(1'b1, 16'd0, 16'hFFFF);
        send_order(1'b0, 16'hFFFF, 16'hFFFF);

        n_rand = 400;
        for (int k = 0; k < n_rand; k++) begin
            if (k == n_rand - 60) gaps_on = 0;
            pick = $urandom_range(0, 99);
            s = 1'($urandom);
            if (pick < 70) begin
                p = 16'($urandom_range(990, 1010));
                q = 16'($urandom_range(1, 60));
            end else if (pick < 80) begin
                p = s ? 16'($urandom_range(1011, 1100)) : 16'($urandom_range(900, 989));
                q = 16'($urandom_range(1, 500));
            end else if (pick < 85) begin
                p = 16'($urandom);
                q = 16'd0;
            end else begin
                p = 16'($urandom);
                q = 16'($urandom);
            end
            send_order(s, p, q);
        end
        i_s_tvalid <= 0;
        wait (fills_due.size() == 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule
